FILE: design/eesd_pkg.sv
// Shared types, codes and helpers for the escaped edit stream decoder.
// Depends on nothing; imported by eesd_core and escaped_edit_stream_decoder_top.
`default_nettype none

package eesd_pkg;

    // Cursor and number width; the result fields stay 24 bits wide.
    localparam int POS_BITS   = 24;
    localparam int FIELD_BITS = 24;
    localparam int USER_BITS  = 16;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Stream characters
    localparam logic [7:0] CH_ESC  = 8'h5C;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_U    = 8'h55;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [2:0] {
        PH_TEXT  = 3'd0,
        PH_ESC   = 3'd1,
        PH_NUM_P = 3'd2,
        PH_NUM_D = 3'd3,
        PH_NUM_U = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef struct packed {
        phase_t                phase;
        logic [POS_BITS-1:0]   acc;
        logic [POS_BITS-1:0]   cursor;
        logic [USER_BITS-1:0]  user;
    } dec_state_t;

    typedef struct packed {
        logic                 emit;
        kind_t                kind;
        logic [POS_BITS-1:0]  pos;
        logic [7:0]           ch;
        logic [POS_BITS-1:0]  cnt;
    } dec_result_t;

    // Keep the low 24 bits of a cursor-wide value, zero-extending if narrower.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+FIELD_BITS-1:0] w;
        w = {{FIELD_BITS{1'b0}}, v};
        return w[FIELD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/eesd_core.sv
// Combinational step of the decoder: next parser state and result for one byte.
// Depends on eesd_pkg.
`default_nettype none

module eesd_core (
    input  wire eesd_pkg::dec_state_t              st,
    input  wire logic [7:0]                        byte_val,
    input  wire logic [eesd_pkg::USER_BITS-1:0]    own_id,
    output eesd_pkg::dec_state_t                   st_next,
    output eesd_pkg::dec_result_t                  res
);
    import eesd_pkg::*;

    logic                          reporting;
    logic                          is_digit;
    logic [POS_BITS-1:0]           cursor_inc;
    logic [POS_BITS+3:0]           acc_wide;
    logic [POS_BITS+3:0]           acc_prod;
    logic [POS_BITS-1:0]           acc_sat;
    logic [POS_BITS+USER_BITS-1:0] acc_user;
    logic [USER_BITS-1:0]          user_sat;
    logic [POS_BITS-1:0]           removed;
    logic [POS_BITS-1:0]           cursor_back;
    logic [POS_BITS-1:0]           cursor_cmd;

    always_comb
    begin
        reporting  = (st.user != own_id);
        is_digit   = (byte_val >= CH_ZERO) && (byte_val <= CH_NINE);
        cursor_inc = (st.cursor == POS_MAX) ? st.cursor : st.cursor + POS_BITS'(1);

        // acc * 10 + digit, saturated to the cursor range
        acc_wide = {4'b0, st.acc};
        acc_prod = (acc_wide << 3) + (acc_wide << 1) + {{POS_BITS{1'b0}}, byte_val[3:0]};
        acc_sat  = (acc_prod > {4'b0, POS_MAX}) ? POS_MAX : acc_prod[POS_BITS-1:0];

        acc_user = {{USER_BITS{1'b0}}, st.acc};
        user_sat = (acc_user > {{POS_BITS{1'b0}}, {USER_BITS{1'b1}}}) ?
                   {USER_BITS{1'b1}} : acc_user[USER_BITS-1:0];

        removed     = (st.acc > st.cursor) ? st.cursor : st.acc;
        cursor_back = st.cursor - removed;
    end

    // Cursor after a finished number command
    always_comb
    begin
        case (st.phase)
            PH_NUM_P: cursor_cmd = st.acc;
            PH_NUM_D: cursor_cmd = cursor_back;
            default:  cursor_cmd = st.cursor;
        endcase
    end

    always_comb
    begin
        st_next  = st;
        res.emit = 1'b0;
        res.kind = KIND_INSERT;
        res.pos  = st.cursor;
        res.ch   = 8'd0;
        res.cnt  = '0;

        unique case (st.phase) inside
            PH_TEXT:
            begin
                if (byte_val == CH_ESC)
                begin
                    st_next.phase = PH_ESC;
                end
                else
                begin
                    res.emit      = reporting;
                    res.ch        = byte_val;
                    st_next.cursor = cursor_inc;
                end
            end
            PH_ESC:
            begin
                st_next.phase = PH_TEXT;
                st_next.acc   = '0;
                unique case (byte_val)
                    CH_P: st_next.phase = PH_NUM_P;
                    CH_D: st_next.phase = PH_NUM_D;
                    CH_U: st_next.phase = PH_NUM_U;
                    CH_A: ;
                    CH_ESC:
                    begin
                        // Doubled escape inserts a literal backslash
                        res.emit       = reporting;
                        res.ch         = CH_ESC;
                        st_next.cursor = cursor_inc;
                    end
                    default:
                    begin
                        // Unknown letter: error at the old cursor, then a
                        // backslash counts as inserted
                        res.emit       = 1'b1;
                        res.kind       = KIND_ERROR;
                        st_next.cursor = cursor_inc;
                    end
                endcase
            end
            PH_NUM_P, PH_NUM_D, PH_NUM_U:
            begin
                if (is_digit)
                begin
                    st_next.acc = acc_sat;
                end
                else
                begin
                    st_next.phase  = PH_TEXT;
                    st_next.acc    = '0;
                    st_next.cursor = cursor_cmd;
                    if (st.phase == PH_NUM_U)
                    begin
                        st_next.user = user_sat;
                    end
                    res.pos = cursor_cmd;
                    if (byte_val != CH_ESC)
                    begin
                        // Missing terminator: command applied, error reported
                        res.emit = 1'b1;
                        res.kind = KIND_ERROR;
                    end
                    else if (st.phase == PH_NUM_D)
                    begin
                        res.emit = reporting;
                        res.kind = KIND_REMOVE;
                        res.cnt  = removed;
                    end
                end
            end
            default:
            begin
                st_next.phase = PH_TEXT;
                st_next.acc   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/escaped_edit_stream_decoder_top.sv
// Top level of the escaped edit stream decoder: handshakes, registers, config.
// Depends on eesd_pkg and eesd_core.
//
// Decodes an edit stream one byte per beat. A backslash opens a command:
// "P<n>\" sets the cursor, "D<n>\" moves it back by n and reports a removal,
// "U<n>\" selects the active user, "A" does nothing and "\\" inserts a
// backslash. Every other byte is text, reported as an insert at the cursor,
// which then advances. Inserts and removals are reported only while the active
// user differs from own_user_id (to be written through cfg_we/cfg_wdata only
// while the block is idle, which the block itself does not enforce); errors
// are always reported. A byte is registered in the input register on
// acceptance; it is then decoded and applied to the parser state, and its
// result (if any) is loaded into the output register, once that register is
// free or being emptied. Sustained rate is one byte per clock while the output
// is not stalled; a new byte is taken while an earlier result waits, and input
// stalls only when the output register is full and stalled with a decoded byte
// behind it. Numbers saturate at the cursor maximum, the cursor saturates at
// zero and at its maximum, and no clearing pass is needed after reset.
`default_nettype none

module escaped_edit_stream_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  byte_in,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       event_kind,
    output logic [23:0]      edit_position,
    output logic [7:0]       text_byte,
    output logic [23:0]      remove_count
);
    import eesd_pkg::*;

    logic [USER_BITS-1:0] own_id_reg;

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;

    dec_state_t           state_reg;
    dec_state_t           state_next;
    dec_result_t          step_res;

    logic                 out_valid_reg;
    dec_result_t          out_reg;

    logic                 advance;

    // Decode stage moves when the output register is free or being emptied
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    eesd_core u_core (
        .st       (state_reg),
        .byte_val (byte_reg),
        .own_id   (own_id_reg),
        .st_next  (state_next),
        .res      (step_res)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            own_id_reg <= cfg_wdata;
        end
    end

    // Input register: take a beat whenever the held byte is gone or leaving
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= byte_in;
        end
    end

    // Parser state: advance once per decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase  <= PH_TEXT;
            state_reg.acc    <= '0;
            state_reg.cursor <= '0;
            state_reg.user   <= '0;
        end
        else if (advance && in_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    // Output register: load a result, drop the valid when nothing new comes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && step_res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && step_res.emit)
        begin
            out_reg <= step_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_reg.kind;
    assign edit_position = to_field(out_reg.pos);
    assign text_byte     = out_reg.ch;
    assign remove_count  = to_field(out_reg.cnt);

    // The accumulator is cleared whenever the parser is outside a number
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_TEXT || state_reg.phase == PH_ESC) |-> state_reg.acc == '0)
        else $error("accumulator not clear outside a number");

    // Input holds off only behind a full, stalled output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled without a blocked output");

    // Only inserts carry a character; only removals carry a count
    a_payload_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.kind == KIND_INSERT || out_reg.ch == 8'd0) &&
                           (out_reg.kind == KIND_REMOVE || out_reg.cnt == '0)))
        else $error("result payload does not match its kind");

    // Parser state never moves while a decoded byte is held back
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(state_reg))
        else $error("parser state changed while output stalled");

endmodule

`default_nettype wire
